### sv/plcc_pkg.sv
// shared types, codes and default palette for the colour-cycling palette store
package plcc_pkg;

  localparam int ENTRIES_DEF      = 256;
  localparam int BASE_COLOURS_DEF = 16;

  typedef enum logic [2:0] {
    OP_LOOKUP   = 3'd0,
    OP_WRITE    = 3'd1,
    OP_ROT_UP   = 3'd2,
    OP_ROT_DOWN = 3'd3,
    OP_RESTORE  = 3'd4
  } op_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SEED,
    SEQ_WALK,
    SEQ_DRAIN
  } seq_state_t;

  // base colours, already scaled to 8 bits, packed {alpha, blue, green, red}
  localparam logic [31:0] BASE_TABLE [16] = '{
    32'hff000000, 32'hff0000a1, 32'hff2828f2, 32'hff408100,
    32'hff28f228, 32'hff814000, 32'hfff22828, 32'hff818181,
    32'hffc2c2c2, 32'hff40a1a1, 32'hff28f2f2, 32'hfff2b6a1,
    32'hfff2de65, 32'hff3c3ca1, 32'hff3c79ca, 32'hfff2f2f2
  };

  // colour an entry holds after reset or restore
  function automatic logic [31:0] default_colour(input logic [7:0] idx,
                                                 input logic [8:0] base);
    logic [7:0]  t;
    logic [10:0] t5;
    logic [31:0] c;
    t  = 8'({1'b0, idx} - base);
    t5 = 11'(t) * 11'd5;
    if (idx < 8'd16 && {1'b0, idx} < base) begin
      c = BASE_TABLE[idx[3:0]];
    end else if ({1'b0, idx} < base) begin
      c = {8'hff, 24'h000000};
    end else begin
      c = {8'hff, 8'hff - t, t5[7:0], t};
    end
    return c;
  endfunction

endpackage

### sv/palette_lookup_with_color_cycling.sv
// palette store with lookup, write, range rotation and restore
//
//   channel  direction  words
//   in_*     input      opcode, entry index, span, colour to write
//   out_*    output     colour bytes and status, one word per input word
//
// lookups, writes, restores and bad requests are taken one per cycle, back to back, while in_stall is low;
// a word reaches out_ through the memory read register, then the output register
// a rotation holds in_stall through its seed read, its walk and a drain state: the single read port walks the range
// one entry a cycle, each entry written back in the cycle after it is read
// reset and restore clear one valid flag per entry at once; no clearing pass
// out_stall holds the output register and, once the stage behind it is full, the input
module palette_lookup_with_color_cycling #(
  parameter int ENTRIES      = plcc_pkg::ENTRIES_DEF,
  parameter int BASE_COLOURS = plcc_pkg::BASE_COLOURS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_entry_index,
  input  logic [8:0] in_span,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_alpha_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [7:0] out_alpha_out,
  output logic       out_status
);
  import plcc_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [8:0] IDX_LIM = 9'(ENTRIES);
  localparam logic [9:0] END_LIM = 10'(ENTRIES);
  localparam logic [8:0] BASE_N  = 9'(BASE_COLOURS);

  // storage
  logic [31:0]        palette_mem [ENTRIES];
  logic [ENTRIES-1:0] ent_valid_r;
  logic [31:0]        rd_data_r;
  logic               rd_valid_r;
  logic [AW-1:0]      rd_addr_r;
  logic [31:0]        rd_colour;

  // port controls
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [31:0]   mem_wd;

  // decode
  logic          acc;
  op_t           op;
  logic          idx_ok, rot_ok;
  logic [9:0]    range_end;
  logic [AW-1:0] idx_a, last_a;
  logic          host_re, host_we, restore, rot_start, acc_status;

  // rotation sequencer
  seq_state_t    state_r, state_nxt;
  logic          up_r;
  logic [AW-1:0] seed_r, wa_r, rq_addr_r;
  logic [8:0]    left_r;
  logic [31:0]   carry_r;
  logic          rq_seed_r, rq_walk_r;
  logic          seq_re, issue_seed, issue_walk;
  logic [AW-1:0] seq_ra;

  // result stage and output register
  logic        s1_v_r, s1_lookup_r, s1_status_r;
  logic        out_free;
  logic        out_valid_r, out_status_r;
  logic [31:0] out_colour_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != SEQ_IDLE) || (s1_v_r && !out_free);
  assign acc      = in_valid && !in_stall;
  assign op       = op_t'(in_opcode);

  always_comb begin
    idx_ok    = {1'b0, in_entry_index} < IDX_LIM;
    range_end = {2'b00, in_entry_index} + {1'b0, in_span};
    rot_ok    = (in_span >= 9'd2) && idx_ok && (range_end <= END_LIM);
    idx_a     = AW'(in_entry_index);
    last_a    = AW'(range_end - 10'd1);
    host_re   = 1'b0;
    host_we   = 1'b0;
    restore   = 1'b0;
    rot_start = 1'b0;
    acc_status = STATUS_OK;
    case (op)
      OP_LOOKUP: begin
        host_re    = acc && idx_ok;
        acc_status = idx_ok ? STATUS_OK : STATUS_INVALID;
      end
      OP_WRITE: begin
        host_we    = acc && idx_ok;
        acc_status = idx_ok ? STATUS_OK : STATUS_INVALID;
      end
      OP_ROT_UP, OP_ROT_DOWN: begin
        rot_start  = acc && rot_ok;
        acc_status = rot_ok ? STATUS_OK : STATUS_INVALID;
      end
      OP_RESTORE: begin
        restore = acc;
      end
      default: begin
        acc_status = STATUS_INVALID;
      end
    endcase
  end

  // never-written entries read as the default palette
  assign rd_colour = rd_valid_r ? rd_data_r : default_colour(8'(rd_addr_r), BASE_N);

  // one read port, one write port; host and sequencer never need a port together
  assign mem_re = host_re || seq_re;
  assign mem_ra = host_re ? idx_a : seq_ra;
  assign mem_we = host_we || rq_walk_r;
  assign mem_wa = host_we ? idx_a : rq_addr_r;
  assign mem_wd = host_we ? {in_alpha_in, in_blue_in, in_green_in, in_red_in} : carry_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r  <= palette_mem[mem_ra];
      rd_valid_r <= ent_valid_r[mem_ra];
      rd_addr_r  <= mem_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restore) begin
      ent_valid_r <= '0;
    end else if (mem_we) begin
      ent_valid_r[mem_wa] <= 1'b1;
    end
  end

  // sequencer: read the wrapping entry first, then walk the range carrying one colour
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE:  if (rot_start) state_nxt = SEQ_SEED;
      SEQ_SEED:  state_nxt = SEQ_WALK;
      SEQ_WALK:  if (left_r == 9'd1) state_nxt = SEQ_DRAIN;
      SEQ_DRAIN: state_nxt = SEQ_IDLE;
      default:   state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    seq_re     = 1'b0;
    seq_ra     = wa_r;
    issue_seed = 1'b0;
    issue_walk = 1'b0;
    case (state_r)
      SEQ_SEED: begin
        seq_re     = 1'b1;
        seq_ra     = seed_r;
        issue_seed = 1'b1;
      end
      SEQ_WALK: begin
        seq_re     = 1'b1;
        issue_walk = 1'b1;
      end
      default: begin
        seq_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SEQ_IDLE;
      rq_seed_r <= 1'b0;
      rq_walk_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rq_seed_r <= issue_seed;
      rq_walk_r <= issue_walk;
    end
  end

  always_ff @(posedge clk) begin
    if (rot_start) begin
      up_r   <= (op == OP_ROT_UP);
      seed_r <= (op == OP_ROT_UP) ? last_a : idx_a;
      wa_r   <= (op == OP_ROT_UP) ? idx_a : last_a;
      left_r <= in_span;
    end else if (issue_walk) begin
      wa_r   <= up_r ? wa_r + AW'(1) : wa_r - AW'(1);
      left_r <= left_r - 9'd1;
    end
    if (seq_re) begin
      rq_addr_r <= seq_ra;
    end
    if (rq_seed_r || rq_walk_r) begin
      carry_r <= rd_colour;
    end
  end

  // result stage: waits for read data, then moves into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (out_free) begin
        s1_v_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_lookup_r <= host_re;
      s1_status_r <= acc_status;
    end
    if (out_free && s1_v_r) begin
      out_colour_r <= s1_lookup_r ? rd_colour : 32'h0;
      out_status_r <= s1_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_colour_r[7:0];
  assign out_green_out = out_colour_r[15:8];
  assign out_blue_out  = out_colour_r[23:16];
  assign out_alpha_out = out_colour_r[31:24];
  assign out_status    = out_status_r;

endmodule

### sv/plcc_chk.sv
// port checker for the palette store, bound to the top level
module plcc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_opcode,
  input logic [7:0] in_entry_index,
  input logic [8:0] in_span,
  input logic [7:0] in_red_in,
  input logic [7:0] in_green_in,
  input logic [7:0] in_blue_in,
  input logic [7:0] in_alpha_in,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic [7:0] out_alpha_out,
  input logic       out_status
);
  import plcc_pkg::*;

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out) && $stable(out_alpha_out))
    else $error("output word changed while stalled");

  // a failed request carries no colour
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_INVALID) |->
      out_red_out == 8'h00 && out_green_out == 8'h00 &&
      out_blue_out == 8'h00 && out_alpha_out == 8'h00)
    else $error("invalid status with non-zero colour");

  // nothing leaves the block straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word right after reset");

endmodule

bind palette_lookup_with_color_cycling plcc_chk u_plcc_chk (.*);

### verif/palette_lookup_with_color_cycling_tb.sv
// self-checking testbench for the colour-cycling palette store
`timescale 1ns / 100ps

module palette_lookup_with_color_cycling_tb;
  import plcc_pkg::*;

  localparam int NUM_ENTRIES  = ENTRIES_DEF;
  localparam int NUM_BASE     = BASE_COLOURS_DEF;
  localparam int DIR_WORDS    = 25;
  localparam int RAND_WORDS   = 1625;
  localparam int TOTAL_WORDS  = DIR_WORDS + RAND_WORDS;
  localparam int CALM_TAIL    = 200;
  localparam int LONG_HOLD    = 80;
  localparam int HOLD_AT      = 300;
  localparam int MAX_REPORTS  = 10;

  localparam logic [2:0] OPC_UNDEF_LO = 3'd5;
  localparam logic [2:0] OPC_UNDEF_HI = 3'd7;

  typedef struct {
    logic [2:0]  opcode;
    logic [7:0]  idx;
    logic [8:0]  span;
    logic [31:0] wcol;     // {alpha, blue, green, red}
  } palette_req_t;

  typedef struct {
    logic [31:0] colour;
    logic        status;
  } palette_resp_t;

  typedef struct {
    logic [2:0]  opcode;
    logic [7:0]  idx;
    logic [8:0]  span;
    logic [31:0] wcol;
    bit          fixed;
    logic [31:0] colour;
    logic        status;
  } dir_row_t;

  // 6-bit base levels, red green blue
  localparam logic [5:0] BASE_LEVELS [16][3] = '{
    '{6'd0,  6'd0,  6'd0 }, '{6'd40, 6'd0,  6'd0 }, '{6'd60, 6'd10, 6'd10},
    '{6'd0,  6'd32, 6'd16}, '{6'd10, 6'd60, 6'd10}, '{6'd0,  6'd16, 6'd32},
    '{6'd10, 6'd10, 6'd60}, '{6'd32, 6'd32, 6'd32}, '{6'd48, 6'd48, 6'd48},
    '{6'd40, 6'd40, 6'd16}, '{6'd60, 6'd60, 6'd10}, '{6'd40, 6'd45, 6'd60},
    '{6'd25, 6'd55, 6'd60}, '{6'd40, 6'd15, 6'd15}, '{6'd50, 6'd30, 6'd15},
    '{6'd60, 6'd60, 6'd60}
  };

  dir_row_t dir_rows [DIR_WORDS] = '{
    '{OP_LOOKUP,    8'd0,   9'd0,   32'h0,        1'b1, 32'hff000000, STATUS_OK},
    '{OP_LOOKUP,    8'd15,  9'd0,   32'h0,        1'b1, 32'hfff2f2f2, STATUS_OK},
    '{OP_LOOKUP,    8'd16,  9'd0,   32'h0,        1'b1, 32'hffff0000, STATUS_OK},
    '{OP_LOOKUP,    8'd255, 9'd0,   32'h0,        1'b1, 32'hff10abef, STATUS_OK},
    '{OP_WRITE,     8'd255, 9'd0,   32'hffffffff, 1'b1, 32'h0,        STATUS_OK},
    '{OP_LOOKUP,    8'd255, 9'd0,   32'h0,        1'b1, 32'hffffffff, STATUS_OK},
    '{OP_WRITE,     8'd0,   9'd0,   32'h0,        1'b1, 32'h0,        STATUS_OK},
    '{OP_LOOKUP,    8'd0,   9'd0,   32'h0,        1'b1, 32'h0,        STATUS_OK},
    '{OP_ROT_UP,    8'd0,   9'd0,   32'h0,        1'b1, 32'h0,        STATUS_INVALID},
    '{OP_ROT_DOWN,  8'd10,  9'd1,   32'h0,        1'b1, 32'h0,        STATUS_INVALID},
    '{OP_ROT_UP,    8'd200, 9'd57,  32'h0,        1'b1, 32'h0,        STATUS_INVALID},
    '{OP_ROT_DOWN,  8'd255, 9'd256, 32'h0,        1'b1, 32'h0,        STATUS_INVALID},
    '{OP_ROT_UP,    8'd255, 9'd511, 32'h0,        1'b1, 32'h0,        STATUS_INVALID},
    '{OPC_UNDEF_LO, 8'd255, 9'd511, 32'hffffffff, 1'b1, 32'h0,        STATUS_INVALID},
    '{OPC_UNDEF_HI, 8'd3,   9'd4,   32'h12345678, 1'b1, 32'h0,        STATUS_INVALID},
    '{OP_ROT_UP,    8'd0,   9'd256, 32'h0,        1'b0, 32'h0,        STATUS_OK},
    '{OP_LOOKUP,    8'd0,   9'd0,   32'h0,        1'b0, 32'h0,        STATUS_OK},
    '{OP_ROT_DOWN,  8'd254, 9'd2,   32'h0,        1'b0, 32'h0,        STATUS_OK},
    '{OP_LOOKUP,    8'd254, 9'd0,   32'h0,        1'b0, 32'h0,        STATUS_OK},
    '{OP_LOOKUP,    8'd255, 9'd0,   32'h0,        1'b0, 32'h0,        STATUS_OK},
    '{OP_ROT_DOWN,  8'd0,   9'd256, 32'h0,        1'b0, 32'h0,        STATUS_OK},
    '{OP_LOOKUP,    8'd1,   9'd0,   32'h0,        1'b0, 32'h0,        STATUS_OK},
    '{OP_RESTORE,   8'd0,   9'd0,   32'h0,        1'b1, 32'h0,        STATUS_OK},
    '{OP_LOOKUP,    8'd255, 9'd0,   32'h0,        1'b1, 32'hff10abef, STATUS_OK},
    '{OP_LOOKUP,    8'd7,   9'd0,   32'h0,        1'b1, 32'hff818181, STATUS_OK}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_opcode = '0;
  logic [7:0] in_entry_index = '0;
  logic [8:0] in_span = '0;
  logic [7:0] in_red_in = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic [7:0] in_alpha_in = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic [7:0] out_alpha_out;
  logic       out_status;

  logic [31:0]   shadow_palette [NUM_ENTRIES];
  palette_resp_t colour_due_q [$];
  int            mismatches = 0;
  int            words_seen = 0;
  bit            tx_idle_on = 1'b0;

  palette_lookup_with_color_cycling u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_span        (in_span),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_alpha_in    (in_alpha_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_alpha_out  (out_alpha_out),
    .out_status     (out_status)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [7:0] scale_to_byte(input logic [5:0] lvl);
    int unsigned v;
    v = (int'(lvl) * 255) / 63;
    return v[7:0];
  endfunction

  function automatic logic [31:0] shadow_default(input int i);
    int unsigned t;
    if (i < 16 && i < NUM_BASE) begin
      return {8'hff, scale_to_byte(BASE_LEVELS[i][2]), scale_to_byte(BASE_LEVELS[i][1]),
              scale_to_byte(BASE_LEVELS[i][0])};
    end else if (i < NUM_BASE) begin
      return 32'hff000000;
    end
    t = (i - NUM_BASE) & 8'hff;
    return {8'hff, 8'(255 - t), 8'((t * 5) & 8'hff), 8'(t)};
  endfunction

  task automatic restore_shadow();
    for (int i = 0; i < NUM_ENTRIES; i++) shadow_palette[i] = shadow_default(i);
  endtask

  // updates the shadow palette and returns the word the block should give back
  task automatic apply_palette_op(input palette_req_t req, output palette_resp_t resp);
    int unsigned s;
    int unsigned n;
    logic [31:0] keep;
    s = req.idx;
    n = req.span;
    resp.colour = '0;
    resp.status = STATUS_OK;
    case (req.opcode)
      OP_LOOKUP: begin
        if (s < NUM_ENTRIES) resp.colour = shadow_palette[s];
        else resp.status = STATUS_INVALID;
      end
      OP_WRITE: begin
        if (s < NUM_ENTRIES) shadow_palette[s] = req.wcol;
        else resp.status = STATUS_INVALID;
      end
      OP_ROT_UP, OP_ROT_DOWN: begin
        if (n < 2 || s >= NUM_ENTRIES || s + n > NUM_ENTRIES) begin
          resp.status = STATUS_INVALID;
        end else if (req.opcode == OP_ROT_UP) begin
          keep = shadow_palette[s + n - 1];
          for (int k = s + n - 1; k > s; k--) shadow_palette[k] = shadow_palette[k - 1];
          shadow_palette[s] = keep;
        end else begin
          keep = shadow_palette[s];
          for (int k = s; k < s + n - 1; k++) shadow_palette[k] = shadow_palette[k + 1];
          shadow_palette[s + n - 1] = keep;
        end
      end
      OP_RESTORE: restore_shadow();
      default: resp.status = STATUS_INVALID;
    endcase
  endtask

  // offers one word, waits for it to be taken, then records what should come back
  task automatic send_word(input palette_req_t req, input bit fixed,
                           input palette_resp_t fixed_resp);
    palette_resp_t resp;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_opcode      <= req.opcode;
    in_entry_index <= req.idx;
    in_span        <= req.span;
    in_red_in      <= req.wcol[7:0];
    in_green_in    <= req.wcol[15:8];
    in_blue_in     <= req.wcol[23:16];
    in_alpha_in    <= req.wcol[31:24];
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_palette_op(req, resp);
    colour_due_q.push_back(fixed ? fixed_resp : resp);
  endtask

  function automatic palette_req_t random_req();
    palette_req_t req;
    int unsigned  pick;
    int unsigned  kind;
    int unsigned  top;
    req.idx  = 8'($urandom_range(0, 255));
    req.span = 9'($urandom_range(0, 511));
    req.wcol = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 55)      req.opcode = OP_LOOKUP;
    else if (pick < 75) req.opcode = OP_WRITE;
    else if (pick < 84) req.opcode = OP_ROT_UP;
    else if (pick < 93) req.opcode = OP_ROT_DOWN;
    else if (pick < 95) req.opcode = OP_RESTORE;
    else                req.opcode = 3'($urandom_range(OPC_UNDEF_LO, OPC_UNDEF_HI));
    if (req.opcode == OP_ROT_UP || req.opcode == OP_ROT_DOWN) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // noise: any start and span
      end else if (kind == 1) begin
        // long range to the end of the store
        req.idx  = 8'($urandom_range(0, 15));
        req.span = 9'(NUM_ENTRIES - req.idx);
      end else if (kind == 2) begin
        req.span = 9'($urandom_range(0, 1));
      end else begin
        req.idx  = 8'($urandom_range(0, 254));
        top      = (NUM_ENTRIES - req.idx < 12) ? NUM_ENTRIES - req.idx : 12;
        req.span = 9'($urandom_range(2, top));
      end
    end
    return req;
  endfunction

  // result side: checking and stall pattern
  int rx_gap_left  = 0;
  int rx_hold_left = 0;
  bit rx_hold_done = 1'b0;
  bit rx_idle_on   = 1'b0;

  always @(posedge clk) begin
    palette_resp_t due;
    logic          stall_next;
    if (rst_n && out_valid && !out_stall) begin
      if (colour_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: colour %h status %b",
                   {out_alpha_out, out_blue_out, out_green_out, out_red_out}, out_status);
      end else begin
        due = colour_due_q.pop_front();
        if (out_red_out !== due.colour[7:0] || out_green_out !== due.colour[15:8] ||
            out_blue_out !== due.colour[23:16] || out_alpha_out !== due.colour[31:24] ||
            out_status !== due.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("word %0d: expected colour %h status %b, got colour %h status %b",
                     words_seen, due.colour, due.status,
                     {out_alpha_out, out_blue_out, out_green_out, out_red_out}, out_status);
        end
      end
      words_seen++;
      if (words_seen % 50 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
    end
    stall_next = 1'b0;
    if (!rst_n) begin
      stall_next = 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      stall_next = 1'b1;
    end else if (!rx_hold_done && words_seen >= HOLD_AT) begin
      // long hold-off so the block backs up into its input
      rx_hold_done = 1'b1;
      rx_hold_left = LONG_HOLD - 1;
      stall_next   = 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      stall_next = 1'b1;
    end else if (rx_idle_on && words_seen < TOTAL_WORDS - CALM_TAIL &&
                 $urandom_range(0, 4) == 0) begin
      rx_gap_left = $urandom_range(1, 5) - 1;
      stall_next  = 1'b1;
    end
    out_stall <= stall_next;
  end

  initial begin
    palette_req_t  req;
    palette_resp_t fixed_resp;
    restore_shadow();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_WORDS; r++) begin
      req.opcode        = dir_rows[r].opcode;
      req.idx           = dir_rows[r].idx;
      req.span          = dir_rows[r].span;
      req.wcol          = dir_rows[r].wcol;
      fixed_resp.colour = dir_rows[r].colour;
      fixed_resp.status = dir_rows[r].status;
      send_word(req, dir_rows[r].fixed, fixed_resp);
    end

    for (int k = 0; k < RAND_WORDS; k++) begin
      if (k % 50 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
      if (k >= RAND_WORDS - CALM_TAIL) tx_idle_on = 1'b0;
      if (k == RAND_WORDS / 2) begin
        // let everything drain before carrying on
        in_valid <= 1'b0;
        while (colour_due_q.size() != 0) @(posedge clk);
      end
      req = random_req();
      send_word(req, 1'b0, fixed_resp);
    end
    in_valid <= 1'b0;

    while (colour_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && colour_due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/plcc_pkg.sv
sv/palette_lookup_with_color_cycling.sv
sv/plcc_chk.sv
verif/palette_lookup_with_color_cycling_tb.sv
